@@ sv/two_level_grid_index_converter_defines.svh @@
// assertion macros for the grid index converter
`ifndef TWO_LEVEL_GRID_INDEX_CONVERTER_DEFINES_SVH
`define TWO_LEVEL_GRID_INDEX_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define TLGIC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tlgic assertion failed");
`define TLGIC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tlgic assertion failed");
`else
`define TLGIC_ASSERT(lbl, prop)
`define TLGIC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ sv/tlgic_pkg.sv @@
// shared types and constants for the grid index converter
package tlgic_pkg;
  localparam int COORD_W = 10;
  localparam int ID_W    = 60;
  localparam int PLANE_W = 2 * COORD_W;
  localparam int COUNT_W = 3 * COORD_W;
  localparam int HALF_W  = COUNT_W / 2;
  localparam int PART_W  = COUNT_W + HALF_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [2:0]         cfg_idx_t;

  localparam cfg_idx_t REG_LOCAL_SIZE_X = 3'd0;
  localparam cfg_idx_t REG_LOCAL_SIZE_Y = 3'd1;
  localparam cfg_idx_t REG_LOCAL_SIZE_Z = 3'd2;
  localparam cfg_idx_t REG_GRID_SIZE_X  = 3'd3;
  localparam cfg_idx_t REG_GRID_SIZE_Y  = 3'd4;
  localparam cfg_idx_t REG_GRID_SIZE_Z  = 3'd5;

  localparam logic CMD_COMPOSE   = 1'b0;
  localparam logic CMD_DECOMPOSE = 1'b1;

  typedef struct packed {
    logic   cmd;
    id_t    gid;
    coord_t lx;
    coord_t ly;
    coord_t lz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } in_item_t;
endpackage

@@ sv/two_level_grid_index_converter.sv @@
// two-level grid index converter: id <-> local point and grid cell
// an item passes the front stages, the divider chain and the output register
// throughput: one item per cycle; busy stays low, the 50-stage divider chain sets latency
// results come out in order, one per item, and cannot be held off
// sync active-low reset clears all valid bits and sets every size register to 1
// derived size products are registered in turn: plane, count, partial products, total
module two_level_grid_index_converter #(
  parameter int SIZE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  tlgic_pkg::id_t           in_global_id,
  input  tlgic_pkg::coord_t        in_local_x,
  input  tlgic_pkg::coord_t        in_local_y,
  input  tlgic_pkg::coord_t        in_local_z,
  input  tlgic_pkg::coord_t        in_cell_x,
  input  tlgic_pkg::coord_t        in_cell_y,
  input  tlgic_pkg::coord_t        in_cell_z,
  output logic                     out_valid,
  output tlgic_pkg::id_t           out_id,
  output tlgic_pkg::coord_t        out_local_x,
  output tlgic_pkg::coord_t        out_local_y,
  output tlgic_pkg::coord_t        out_local_z,
  output tlgic_pkg::coord_t        out_cell_x,
  output tlgic_pkg::coord_t        out_cell_y,
  output tlgic_pkg::coord_t        out_cell_z,
  output logic                     out_in_range,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  tlgic_pkg::cfg_idx_t      cfg_index,
  input  logic [SIZE_BITS-1:0]     cfg_data
);
  import tlgic_pkg::*;

  `include "two_level_grid_index_converter_defines.svh"

  localparam int LAT = 55;

  // configuration
  logic [SIZE_BITS-1:0] lsx_r, lsy_r, lsz_r, gsx_r, gsy_r, gsz_r;
  coord_t sx, sy, sz, gx, gy, gz;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsx_r <= SIZE_BITS'(1);
      lsy_r <= SIZE_BITS'(1);
      lsz_r <= SIZE_BITS'(1);
      gsx_r <= SIZE_BITS'(1);
      gsy_r <= SIZE_BITS'(1);
      gsz_r <= SIZE_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCAL_SIZE_X: lsx_r <= cfg_data;
        REG_LOCAL_SIZE_Y: lsy_r <= cfg_data;
        REG_LOCAL_SIZE_Z: lsz_r <= cfg_data;
        REG_GRID_SIZE_X:  gsx_r <= cfg_data;
        REG_GRID_SIZE_Y:  gsy_r <= cfg_data;
        REG_GRID_SIZE_Z:  gsz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sx = COORD_W'(lsx_r);
  assign sy = COORD_W'(lsy_r);
  assign sz = COORD_W'(lsz_r);
  assign gx = COORD_W'(gsx_r);
  assign gy = COORD_W'(gsy_r);
  assign gz = COORD_W'(gsz_r);

  // size products, recomputed every cycle
  logic [PLANE_W-1:0] lplane_r, gplane_r;
  logic [COUNT_W-1:0] lcount_r, gcount_r;
  logic [PART_W-1:0]  tot_lo_r, tot_hi_r;
  id_t                total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lplane_r <= PLANE_W'(1);
      gplane_r <= PLANE_W'(1);
      lcount_r <= COUNT_W'(1);
      gcount_r <= COUNT_W'(1);
      tot_lo_r <= PART_W'(1);
      tot_hi_r <= '0;
      total_r  <= ID_W'(1);
    end else begin
      lplane_r <= PLANE_W'(sx) * PLANE_W'(sy);
      gplane_r <= PLANE_W'(gx) * PLANE_W'(gy);
      lcount_r <= COUNT_W'(lplane_r) * COUNT_W'(sz);
      gcount_r <= COUNT_W'(gplane_r) * COUNT_W'(gz);
      tot_lo_r <= PART_W'(lcount_r) * PART_W'(gcount_r[HALF_W-1:0]);
      tot_hi_r <= PART_W'(lcount_r) * PART_W'(gcount_r[COUNT_W-1:HALF_W]);
      total_r  <= ID_W'(tot_lo_r) + (ID_W'(tot_hi_r) << HALF_W);
    end
  end

  // front stages: capture, compose products, range check
  logic               v0_r, v1_r, v2_r, v3_r, v4_r;
  in_item_t           it0_r, it1_r, it2_r, it3_r, it4_r;
  logic               ok1_r, ok2_r, ok3_r, ok4_r;
  logic [PLANE_W-1:0] lpy_r, gpy_r;
  logic [COUNT_W-1:0] lid2_r, cid2_r, lid3_r;
  logic [PART_W-1:0]  plo_r, phi_r;
  id_t                id4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    it0_r <= '{cmd: in_command, gid: in_global_id, lx: in_local_x, ly: in_local_y,
               lz: in_local_z, cx: in_cell_x, cy: in_cell_y, cz: in_cell_z};

    it1_r <= it0_r;
    ok1_r <= (it0_r.lx < sx) && (it0_r.ly < sy) && (it0_r.lz < sz) &&
             (it0_r.cx < gx) && (it0_r.cy < gy) && (it0_r.cz < gz);
    lpy_r <= PLANE_W'(it0_r.ly) * PLANE_W'(sx);
    gpy_r <= PLANE_W'(it0_r.cy) * PLANE_W'(gx);

    it2_r  <= it1_r;
    ok2_r  <= ok1_r;
    lid2_r <= COUNT_W'(it1_r.lx) + COUNT_W'(lpy_r) +
              COUNT_W'(lplane_r) * COUNT_W'(it1_r.lz);
    cid2_r <= COUNT_W'(it1_r.cx) + COUNT_W'(gpy_r) +
              COUNT_W'(gplane_r) * COUNT_W'(it1_r.cz);

    it3_r  <= it2_r;
    ok3_r  <= ok2_r;
    lid3_r <= lid2_r;
    plo_r  <= PART_W'(lcount_r) * PART_W'(cid2_r[HALF_W-1:0]);
    phi_r  <= PART_W'(lcount_r) * PART_W'(cid2_r[COUNT_W-1:HALF_W]);

    it4_r <= it3_r;
    ok4_r <= (it3_r.cmd == CMD_COMPOSE) ? ok3_r : (it3_r.gid < total_r);
    id4_r <= ID_W'(lid3_r) + ID_W'(plo_r) + (ID_W'(phi_r) << HALF_W);
  end

  // divider chain: id / local count, then plane, then row
  localparam int ECHO_W = 6 * COORD_W;
  localparam int D1S_W  = 2 + ID_W + ECHO_W;
  localparam int LS2_W  = 2 + ID_W;
  localparam int LS3_W  = LS2_W + COORD_W;
  localparam int CS3_W  = ECHO_W + COORD_W;

  logic               d1_vld;
  logic [COUNT_W-1:0] d1_quo, d1_rem;
  logic [D1S_W-1:0]   d1_side;

  tlgic_div_pipe #(.NUM_W(ID_W), .DEN_W(COUNT_W), .Q_W(COUNT_W), .SIDE_W(D1S_W)) u_div_id (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .num(it4_r.gid), .den(lcount_r),
    .side_in({it4_r.cmd, ok4_r, id4_r, it4_r.lx, it4_r.ly, it4_r.lz,
              it4_r.cx, it4_r.cy, it4_r.cz}),
    .out_valid(d1_vld), .quo(d1_quo), .rem(d1_rem), .side_out(d1_side)
  );

  logic               l2_vld, c2_vld;
  coord_t             l2_quo, c2_quo;
  logic [PLANE_W-1:0] l2_rem, c2_rem;
  logic [LS2_W-1:0]   l2_side;
  logic [ECHO_W-1:0]  c2_side;

  tlgic_div_pipe #(.NUM_W(COUNT_W), .DEN_W(PLANE_W), .Q_W(COORD_W), .SIDE_W(LS2_W)) u_div_lz (
    .clk(clk), .rst_n(rst_n), .in_valid(d1_vld), .num(d1_rem), .den(lplane_r),
    .side_in(d1_side[D1S_W-1:ECHO_W]),
    .out_valid(l2_vld), .quo(l2_quo), .rem(l2_rem), .side_out(l2_side)
  );

  tlgic_div_pipe #(.NUM_W(COUNT_W), .DEN_W(PLANE_W), .Q_W(COORD_W), .SIDE_W(ECHO_W)) u_div_cz (
    .clk(clk), .rst_n(rst_n), .in_valid(d1_vld), .num(d1_quo), .den(gplane_r),
    .side_in(d1_side[ECHO_W-1:0]),
    .out_valid(c2_vld), .quo(c2_quo), .rem(c2_rem), .side_out(c2_side)
  );

  logic             l3_vld, c3_vld;
  coord_t           l3_quo, l3_rem, c3_quo, c3_rem;
  logic [LS3_W-1:0] l3_side;
  logic [CS3_W-1:0] c3_side;

  tlgic_div_pipe #(.NUM_W(PLANE_W), .DEN_W(COORD_W), .Q_W(COORD_W), .SIDE_W(LS3_W)) u_div_ly (
    .clk(clk), .rst_n(rst_n), .in_valid(l2_vld), .num(l2_rem), .den(sx),
    .side_in({l2_side, l2_quo}),
    .out_valid(l3_vld), .quo(l3_quo), .rem(l3_rem), .side_out(l3_side)
  );

  tlgic_div_pipe #(.NUM_W(PLANE_W), .DEN_W(COORD_W), .Q_W(COORD_W), .SIDE_W(CS3_W)) u_div_cy (
    .clk(clk), .rst_n(rst_n), .in_valid(c2_vld), .num(c2_rem), .den(gx),
    .side_in({c2_side, c2_quo}),
    .out_valid(c3_vld), .quo(c3_quo), .rem(c3_rem), .side_out(c3_side)
  );

  // result select and output register
  logic   f_cmd, f_ok;
  id_t    f_id;
  coord_t f_lz, f_cz;
  logic [ECHO_W-1:0] f_echo;

  assign {f_cmd, f_ok, f_id, f_lz} = l3_side;
  assign {f_echo, f_cz}            = c3_side;

  logic   out_valid_r;
  id_t    id_nxt, id_r;
  coord_t lx_nxt, ly_nxt, lz_nxt, cx_nxt, cy_nxt, cz_nxt;
  coord_t lx_r, ly_r, lz_r, cx_r, cy_r, cz_r;
  logic   rng_r;

  always_comb begin
    id_nxt = '0;
    lx_nxt = '0;
    ly_nxt = '0;
    lz_nxt = '0;
    cx_nxt = '0;
    cy_nxt = '0;
    cz_nxt = '0;
    if (f_ok) begin
      if (f_cmd == CMD_COMPOSE) begin
        id_nxt = f_id;
        {lx_nxt, ly_nxt, lz_nxt, cx_nxt, cy_nxt, cz_nxt} = f_echo;
      end else begin
        lx_nxt = l3_rem;
        ly_nxt = l3_quo;
        lz_nxt = f_lz;
        cx_nxt = c3_rem;
        cy_nxt = c3_quo;
        cz_nxt = f_cz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= l3_vld;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    lx_r  <= lx_nxt;
    ly_r  <= ly_nxt;
    lz_r  <= lz_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    cz_r  <= cz_nxt;
    rng_r <= f_ok;
  end

  assign out_valid    = out_valid_r;
  assign out_id       = id_r;
  assign out_local_x  = lx_r;
  assign out_local_y  = ly_r;
  assign out_local_z  = lz_r;
  assign out_cell_x   = cx_r;
  assign out_cell_y   = cy_r;
  assign out_cell_z   = cz_r;
  assign out_in_range = rng_r;

  // both divider lanes stay in step
  `TLGIC_ASSERT(a_lanes_d2, l2_vld == c2_vld)
  `TLGIC_ASSERT(a_lanes_d3, l3_vld == c3_vld)
  // an out-of-range result carries all zero fields
  `TLGIC_ASSERT(a_zero_oor, out_valid && !out_in_range |-> out_id == '0 &&
    out_local_x == '0 && out_local_y == '0 && out_local_z == '0 &&
    out_cell_x == '0 && out_cell_y == '0 && out_cell_z == '0)
  // every result traces back to an accepted item
  `TLGIC_ASSERT(a_latency, out_valid |-> $past(start && !busy, LAT + 1))
  `TLGIC_ASSERT_ALWAYS(a_no_busy, !busy)
endmodule

@@ sv/tlgic_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage
module tlgic_div_pipe #(
  parameter int NUM_W  = 60,
  parameter int DEN_W  = 30,
  parameter int Q_W    = 30,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);
  localparam int SH_W = NUM_W + Q_W;

  logic [Q_W-1:0]    vld_r;
  logic [NUM_W-1:0]  rem_r  [Q_W];
  logic [Q_W-1:0]    quo_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [Q_W-1:0]    quo_in;
    logic [SIDE_W-1:0] side_k;
    logic [SH_W-1:0]   dsh;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = num;
      assign quo_in = '0;
      assign side_k = side_in;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign side_k = side_r[k-1];
    end

    // trial subtract of the divisor at this bit weight
    assign dsh  = SH_W'(den) << (Q_W - 1 - k);
    assign take = SH_W'(rem_in) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? NUM_W'(SH_W'(rem_in) - dsh) : rem_in;
      quo_r[k]  <= quo_in | (take ? (Q_W'(1) << (Q_W - 1 - k)) : Q_W'(0));
      side_r[k] <= side_k;
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign quo       = quo_r[Q_W-1];
  assign rem       = rem_r[Q_W-1][DEN_W-1:0];
  assign side_out  = side_r[Q_W-1];
endmodule
